@@ rtl/cfa_pkg.sv @@
// Shared types and constants for the clock frame allocator.
// Used by every module of the block except cfa_ram; depends on nothing else.
`default_nettype none

package cfa_pkg;

  // Default size of the frame table.
  localparam int NUM_FRAMES_DEF = 64;

  // Fixed field widths of the request and result transfers and the configuration word.
  localparam int ACT_W   = 2;
  localparam int FIDX_PW = 6;
  localparam int TAG_W   = 20;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 7;

  // Frame count after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNPIN = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FRAME  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [FIDX_PW-1:0] frame_index;
    logic [TAG_W-1:0]   page_tag;
  } cfa_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIDX_PW-1:0] granted_frame;
    logic               evicted;
    logic [TAG_W-1:0]   evicted_tag;
  } cfa_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic op_exec;
    logic scan_next;
    logic sweep_init;
    logic sweep_step;
    logic clr_ref;
    logic grant_scan;
    logic grant_hand;
    logic grant_evict;
    logic fail;
  } cfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_alloc;
    logic scan_hit;
    logic scan_last;
    logic sweep_done;
    logic hand_pin;
    logic hand_occ;
    logic hand_ref;
  } cfa_sts_t;

endpackage

`default_nettype wire

@@ rtl/clock_frame_allocator.sv @@
// Mark, unpin and free are decoded and executed, then their result is registered;
// an allocate first scans for the lowest free frame and, if none is found, runs
// the second-chance sweep of up to two turns over the n active frames.
// A new request is accepted only while busy is low; the flag scan reads one frame per cycle.
// Reset (rst_n low, synchronous) frees and unpins every frame and zeroes the
// hand; the tag RAM needs no clearing. Results cannot be stalled.
`default_nettype none

module clock_frame_allocator
  import cfa_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             start,
  input  wire cfa_in_t          in_data,
  output logic                  busy,
  output logic                  out_valid,
  output cfa_out_t              out_data
);

  cfa_cmd_t cmd;
  cfa_sts_t sts;

  // Sequencer.
  cfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Frame table and result register.
  cfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/cfa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the owner tag store.
`default_nettype none

module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/cfa_datapath.sv @@
// Datapath of the clock frame allocator: frame flags, clock hand, scan
// pointer, owner tag RAM and result register. Depends on cfa_pkg and cfa_ram.
`default_nettype none

module cfa_datapath
  import cfa_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire cfa_in_t          in_data,
  input  wire cfa_cmd_t         cmd,
  output cfa_sts_t              sts,
  output logic                  out_valid,
  output cfa_out_t              out_data
);

  localparam int FIDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]      cfg_r;
  logic [ACT_W-1:0]      act_r;
  logic [FIDX_PW-1:0]    idx_r;
  logic [TAG_W-1:0]      tag_r;
  logic [NUM_FRAMES-1:0] occ_r, occ_nxt;
  logic [NUM_FRAMES-1:0] ref_r, ref_nxt;
  logic [NUM_FRAMES-1:0] pin_r, pin_nxt;
  logic [FIDX_W-1:0]     hand_r, hand_nxt;
  logic [FIDX_W-1:0]     ptr_r;
  logic [CNT_W:0]        steps_r;
  logic                  out_valid_r;
  cfa_out_t              out_r, out_nxt;

  logic [CW-1:0]         cfg_ext;
  logic [CNT_W-1:0]      n_act;
  logic                  idx_bad;
  logic [FIDX_W-1:0]     idx_f;
  logic [CNT_W-1:0]      hand_inc;
  logic [CNT_W-1:0]      ptr_inc;
  logic [FIDX_W-1:0]     grant_addr;
  logic                  grant_any;
  logic [STAT_W-1:0]     op_status;
  logic [TAG_W-1:0]      tag_rd;

  // Active frame count: zero acts as one, large values clamp to the table size.
  always_comb begin
    cfg_ext = CW'(cfg_r);
    if (cfg_ext == '0) begin
      n_act = CNT_W'(1);
    end else if (cfg_ext > CW'(NUM_FRAMES)) begin
      n_act = CNT_W'(NUM_FRAMES);
    end else begin
      n_act = CNT_W'(cfg_ext);
    end
  end

  assign idx_bad    = CW'(idx_r) >= CW'(n_act);
  assign idx_f      = FIDX_W'(idx_r);
  assign hand_inc   = CNT_W'(hand_r) + CNT_W'(1);
  assign ptr_inc    = CNT_W'(ptr_r) + CNT_W'(1);
  assign hand_nxt   = (hand_inc == n_act) ? '0 : FIDX_W'(hand_inc);
  assign grant_addr = cmd.grant_hand ? hand_r : ptr_r;
  assign grant_any  = cmd.grant_scan | cmd.grant_hand | cmd.grant_evict;

  // Status toward the controller.
  always_comb begin
    sts.is_alloc   = (act_r == ACT_ALLOC);
    sts.scan_hit   = !occ_r[ptr_r] && !pin_r[ptr_r];
    sts.scan_last  = (ptr_inc == n_act);
    sts.sweep_done = (steps_r == {n_act, 1'b0});
    sts.hand_pin   = pin_r[hand_r];
    sts.hand_occ   = occ_r[hand_r];
    sts.hand_ref   = ref_r[hand_r];
  end

  // Owner tag store; the sweep reads at the hand so an eviction finds
  // the displaced tag in the following cycle.
  cfa_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_FRAMES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (grant_any),
    .wr_addr (grant_addr),
    .wr_data (tag_r),
    .rd_addr (hand_r),
    .rd_data (tag_rd)
  );

  // Next values of the frame flags and the status of a simple action.
  always_comb begin
    occ_nxt   = occ_r;
    ref_nxt   = ref_r;
    pin_nxt   = pin_r;
    op_status = ST_OK;
    if (cmd.op_exec) begin
      if (idx_bad) begin
        op_status = ST_BAD_INDEX;
      end else begin
        case (act_r)
          ACT_MARK: begin
            ref_nxt[idx_f] = 1'b1;
          end
          ACT_UNPIN: begin
            if (!pin_r[idx_f]) begin
              op_status = ST_BAD_INDEX;
            end else begin
              pin_nxt[idx_f] = 1'b0;
            end
          end
          ACT_FREE: begin
            occ_nxt[idx_f] = 1'b0;
            ref_nxt[idx_f] = 1'b0;
            pin_nxt[idx_f] = 1'b0;
          end
          default: begin
            op_status = ST_OK;
          end
        endcase
      end
    end
    if (cmd.clr_ref) begin
      ref_nxt[hand_r] = 1'b0;
    end
    if (grant_any) begin
      occ_nxt[grant_addr] = 1'b1;
      ref_nxt[grant_addr] = 1'b0;
      pin_nxt[grant_addr] = 1'b1;
    end
  end

  // Control state: configuration, flags, hand and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      occ_r       <= '0;
      ref_r       <= '0;
      pin_r       <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      occ_r       <= occ_nxt;
      ref_r       <= ref_nxt;
      pin_r       <= pin_nxt;
      out_valid_r <= cmd.op_exec | grant_any | cmd.fail;
      if (cmd.sweep_init && (CNT_W'(hand_r) >= n_act)) begin
        hand_r <= '0;
      end else if (cmd.sweep_step) begin
        hand_r <= hand_nxt;
      end
    end
  end

  // Request latch, scan pointer and sweep step count.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data.action;
      idx_r <= in_data.frame_index;
      tag_r <= in_data.page_tag;
      ptr_r <= '0;
    end else if (cmd.scan_next) begin
      ptr_r <= FIDX_W'(ptr_inc);
    end else if (cmd.sweep_step) begin
      ptr_r <= hand_r;
    end
    if (cmd.sweep_init) begin
      steps_r <= '0;
    end else if (cmd.sweep_step) begin
      steps_r <= steps_r + (CNT_W + 1)'(1);
    end
  end

  // Next result; fields other than status stay zero unless a grant.
  always_comb begin
    out_nxt = '0;
    if (cmd.op_exec) begin
      out_nxt.status = op_status;
    end else if (cmd.fail) begin
      out_nxt.status = ST_NO_FRAME;
    end else if (grant_any) begin
      out_nxt.status        = ST_OK;
      out_nxt.granted_frame = FIDX_PW'(grant_addr);
      if (cmd.grant_evict) begin
        out_nxt.evicted     = 1'b1;
        out_nxt.evicted_tag = tag_rd;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/cfa_ctrl.sv @@
// Controller of the clock frame allocator: sequences the decode, the free
// frame scan, the clock sweep and the eviction. Depends on cfa_pkg.
`default_nettype none

module cfa_ctrl
  import cfa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire cfa_sts_t sts,
  output logic          busy,
  output cfa_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_EVICT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_alloc) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.op_exec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.grant_scan = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.scan_last) begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SWEEP;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_done) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.sweep_step = 1'b1;
          if (sts.hand_pin) begin
            state_nxt = S_SWEEP;
          end else if (!sts.hand_occ) begin
            cmd.grant_hand = 1'b1;
            state_nxt      = S_IDLE;
          end else if (!sts.hand_ref) begin
            state_nxt = S_EVICT;
          end else begin
            cmd.clr_ref = 1'b1;
          end
        end
      end
      S_EVICT: begin
        cmd.grant_evict = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/cfa_checker.sv @@
// Port-level checks for the clock frame allocator, bound to the top level.
// Depends on cfa_pkg and clock_frame_allocator.
`default_nettype none

module cfa_checker
  import cfa_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire cfa_out_t out_data
);

  // An accepted transfer keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  // A result only follows a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // Status is one of the defined codes.
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_NO_FRAME ||
                   out_data.status == ST_BAD_INDEX))
    else $error("undefined status code");

  // A failed request carries no frame and no eviction.
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.granted_frame == '0 && !out_data.evicted && out_data.evicted_tag == '0))
    else $error("failed result carries payload");

endmodule

bind clock_frame_allocator cfa_checker u_cfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/sv/clock_frame_allocator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the clock frame allocator: directed requests, then random
// request streams over several frame counts, checked against a behavioral frame table.
// Depends on cfa_pkg and clock_frame_allocator.

module clock_frame_allocator_tb;
  import cfa_pkg::*;

  localparam int NF = NUM_FRAMES_DEF;
  // Margin for the longest allocate: a full scan followed by a full second-chance sweep.
  localparam int SETTLE_CYCLES = 3 * NF + 8;

  // Behavioral frame table plus the queue of results it has promised.
  class frame_grant_scoreboard;
    logic [CFG_W-1:0] frames_reg;
    bit               occupied[NF];
    logic [TAG_W-1:0] owner_tag[NF];
    bit               referenced[NF];
    bit               pinned[NF];
    int               hand;
    cfa_out_t         expected_grants[$];
    int               mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      frames_reg = CFG_RESET;
      for (int i = 0; i < NF; i++) begin
        occupied[i]   = 1'b0;
        owner_tag[i]  = '0;
        referenced[i] = 1'b0;
        pinned[i]     = 1'b0;
      end
      hand = 0;
      expected_grants.delete();
    endfunction

    // Out-of-range register values saturate to 1 and NF.
    function int active_frames();
      if (frames_reg == 0) return 1;
      if (frames_reg > NF) return NF;
      return int'(frames_reg);
    endfunction

    function void take_frame(int f, logic [TAG_W-1:0] tag);
      occupied[f]   = 1'b1;
      owner_tag[f]  = tag;
      referenced[f] = 1'b0;
      pinned[f]     = 1'b1;
    endfunction

    // Lowest free frame first, then the second-chance sweep of up to two turns.
    function cfa_out_t allocate(logic [TAG_W-1:0] tag);
      cfa_out_t res;
      int       n;
      int       f;
      res = '0;
      n   = active_frames();
      for (int i = 0; i < n; i++) begin
        if (!occupied[i] && !pinned[i]) begin
          take_frame(i, tag);
          res.granted_frame = FIDX_PW'(i);
          return res;
        end
      end
      if (hand >= n) hand = 0;
      for (int i = 0; i < 2 * n; i++) begin
        f    = hand;
        hand = (hand + 1) % n;
        if (pinned[f]) continue;
        if (!occupied[f]) begin
          take_frame(f, tag);
          res.granted_frame = FIDX_PW'(f);
          return res;
        end
        if (!referenced[f]) begin
          res.evicted     = 1'b1;
          res.evicted_tag = owner_tag[f];
          take_frame(f, tag);
          res.granted_frame = FIDX_PW'(f);
          return res;
        end
        referenced[f] = 1'b0;
      end
      res.status = ST_NO_FRAME;
      return res;
    endfunction

    // Called once per accepted request transfer.
    function void note_request(cfa_in_t req);
      cfa_out_t res;
      int       n;
      int       idx;
      res = '0;
      n   = active_frames();
      idx = int'(req.frame_index);
      if (req.action == ACT_ALLOC) begin
        res = allocate(req.page_tag);
      end else if (idx >= n) begin
        res.status = ST_BAD_INDEX;
      end else begin
        case (req.action)
          ACT_MARK: begin
            referenced[idx] = 1'b1;
          end
          ACT_UNPIN: begin
            if (!pinned[idx]) res.status = ST_BAD_INDEX;
            else pinned[idx] = 1'b0;
          end
          default: begin
            occupied[idx]   = 1'b0;
            referenced[idx] = 1'b0;
            pinned[idx]     = 1'b0;
          end
        endcase
      end
      expected_grants.push_back(res);
    endfunction

    function int pick_pinned(int n);
      int hits[$];
      for (int i = 0; i < n; i++) if (pinned[i]) hits.push_back(i);
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compares one result transfer against the oldest expectation.
    task check_result(cfa_out_t got);
      cfa_out_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
        return;
      end
      want = expected_grants.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.granted_frame !== want.granted_frame)
        report_mismatch($sformatf("granted_frame got %0d want %0d",
                                  got.granted_frame, want.granted_frame));
      if (got.evicted !== want.evicted)
        report_mismatch($sformatf("evicted got %0b want %0b", got.evicted, want.evicted));
      if (got.evicted_tag !== want.evicted_tag)
        report_mismatch($sformatf("evicted_tag got %05h want %05h",
                                  got.evicted_tag, want.evicted_tag));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             start     = 1'b0;
  cfa_in_t          in_data   = '0;
  logic             busy;
  logic             out_valid;
  cfa_out_t         out_data;

  frame_grant_scoreboard sb = new();
  // When set, the sender issues back-to-back requests with no gaps.
  bit steady = 1'b0;

  always #5 clk = ~clk;

  clock_frame_allocator #(
    .NUM_FRAMES(NF)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Results cannot be held off, so every strobe is a transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Holds start until the block takes the request, then idles a random gap.
  task automatic send_request(logic [ACT_W-1:0] act, int idx, logic [TAG_W-1:0] tag);
    cfa_in_t req;
    int      gap;
    req.action      = act;
    req.frame_index = FIDX_PW'(idx);
    req.page_tag    = tag;
    gap = steady ? 0 : $urandom_range(0, 15);
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (sb.expected_grants.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frames(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.frames_reg = value;
  endtask

  // Allocates at alloc_pct percent, else mostly in-range mark/unpin/free, with some out-of-range noise.
  task automatic random_request(int alloc_pct);
    int               r;
    int               n;
    int               idx;
    int               p;
    logic [ACT_W-1:0] act;
    n   = sb.active_frames();
    idx = $urandom_range(0, n - 1);
    r   = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      act = ACT_ALLOC;
      idx = $urandom_range(0, NF - 1);
    end else begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        act = ACT_MARK;
      end else if (r < 8) begin
        act = ACT_UNPIN;
        p   = sb.pick_pinned(n);
        if (p >= 0 && $urandom_range(0, 9) < 8) idx = p;
      end else begin
        act = ACT_FREE;
      end
      if ($urandom_range(0, 99) < 12) idx = $urandom_range(0, NF - 1);
    end
    send_request(act, idx, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)));
  endtask

  task automatic run_phase(logic [CFG_W-1:0] frames, int count, int alloc_pct);
    drain_results();
    write_frames(frames);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      if ($urandom_range(0, 199) == 0) drain_results();
      random_request(alloc_pct);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sb.clear();
    repeat (2) @(posedge clk);

    // Four frames: fill, fail with all pinned, then second chance and eviction.
    write_frames(7'd4);
    send_request(ACT_ALLOC, 0, '0);
    send_request(ACT_ALLOC, NF - 1, '1);
    send_request(ACT_ALLOC, 0, 20'h12345);
    send_request(ACT_ALLOC, 0, 20'hABCDE);
    send_request(ACT_ALLOC, 0, 20'h55555);
    send_request(ACT_UNPIN, 0, '0);
    send_request(ACT_UNPIN, 0, '0);
    send_request(ACT_MARK, 0, '0);
    send_request(ACT_UNPIN, 1, '0);
    send_request(ACT_UNPIN, 2, '0);
    send_request(ACT_ALLOC, 0, 20'h0F0F0);
    // Indexes past the active count.
    send_request(ACT_MARK, 4, '0);
    send_request(ACT_UNPIN, NF - 1, '1);
    send_request(ACT_FREE, 5, '0);
    // Free of a pinned frame, mark of a free frame, then reuse it.
    send_request(ACT_FREE, 3, '0);
    send_request(ACT_MARK, 3, '0);
    send_request(ACT_ALLOC, 0, 20'h3C3C3);
    send_request(ACT_FREE, 0, '0);
    send_request(ACT_ALLOC, 0, 20'h00001);

    // Shrink below the hand so the next sweep restarts it at zero.
    drain_results();
    write_frames(7'd2);
    send_request(ACT_UNPIN, 0, '0);
    send_request(ACT_UNPIN, 1, '0);
    send_request(ACT_ALLOC, 0, 20'h80000);
    send_request(ACT_MARK, 2, '0);

    // Random streams over a range of frame counts, including out-of-range values.
    run_phase(7'd64, 250, 55);
    run_phase(7'd1, 100, 40);
    run_phase(7'd0, 60, 40);
    run_phase(7'd127, 250, 50);
    run_phase(7'd3, 150, 40);
    run_phase(CFG_W'($urandom_range(1, NF)), 200, 45);
    run_phase(CFG_W'($urandom_range(2, 16)), 150, 45);
    run_phase(7'd64, 90, 40);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
